>>> hdl/utf8d_pkg.sv
`default_nettype none
package utf8d_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] MAX_CP         = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;
  localparam logic [20:0] MIN_CP_LEN2    = 21'h000080;
  localparam logic [20:0] MIN_CP_LEN3    = 21'h000800;
  localparam logic [20:0] MIN_CP_LEN4    = 21'h010000;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // One queued entry: rep replacement characters, then optionally cp.
  typedef struct packed {
    logic [1:0]  rep;
    logic        has_cp;
    logic [20:0] cp;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage
`default_nettype wire

>>> hdl/utf8d_front.sv
`default_nettype none
module utf8d_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_of_text_i,
  output logic                   push_o,
  output utf8d_pkg::cmd_t        cmd_o
);

  logic [2:0]  exp_len_q, exp_len_d;
  logic [1:0]  rcv_cnt_q, rcv_cnt_d;
  logic [20:0] partial_q, partial_d;

  logic        is_cont;
  logic [20:0] acc_val;
  logic [2:0]  next_cnt;
  logic        overlong;
  logic        bad_cp;
  logic [20:0] final_cp;

  always_comb begin
    is_cont  = (in_byte_i[7:6] == 2'b10);
    acc_val  = {partial_q[14:0], in_byte_i[5:0]};
    next_cnt = {1'b0, rcv_cnt_q} + 3'd1;
    overlong = ((exp_len_q == utf8d_pkg::LEN_TWO)   && (acc_val < utf8d_pkg::MIN_CP_LEN2)) ||
               ((exp_len_q == utf8d_pkg::LEN_THREE) && (acc_val < utf8d_pkg::MIN_CP_LEN3)) ||
               ((exp_len_q == utf8d_pkg::LEN_FOUR)  && (acc_val < utf8d_pkg::MIN_CP_LEN4));
    bad_cp   = (acc_val > utf8d_pkg::MAX_CP) ||
               ((acc_val >= utf8d_pkg::SURR_LO) && (acc_val <= utf8d_pkg::SURR_HI));
    final_cp = (overlong || bad_cp) ? utf8d_pkg::REPLACEMENT_CP : acc_val;
  end

  always_comb begin
    logic fresh;
    fresh     = 1'b0;
    exp_len_d = exp_len_q;
    rcv_cnt_d = rcv_cnt_q;
    partial_d = partial_q;
    cmd_o.rep    = 2'd0;
    cmd_o.has_cp = 1'b0;
    cmd_o.cp     = utf8d_pkg::REPLACEMENT_CP;

    if (exp_len_q != utf8d_pkg::LEN_NONE) begin
      if (is_cont) begin
        if (next_cnt >= exp_len_q) begin
          cmd_o.has_cp = 1'b1;
          cmd_o.cp     = final_cp;
          exp_len_d    = utf8d_pkg::LEN_NONE;
          rcv_cnt_d    = 2'd0;
          partial_d    = '0;
        end else if (end_of_text_i) begin
          cmd_o.rep = next_cnt[1:0];
          exp_len_d = utf8d_pkg::LEN_NONE;
          rcv_cnt_d = 2'd0;
          partial_d = '0;
        end else begin
          rcv_cnt_d = next_cnt[1:0];
          partial_d = acc_val;
        end
      end else begin
        // broken sequence: flush pending bytes, then decode this byte anew
        cmd_o.rep = rcv_cnt_q;
        exp_len_d = utf8d_pkg::LEN_NONE;
        rcv_cnt_d = 2'd0;
        partial_d = '0;
        fresh     = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!in_byte_i[7]) begin
        cmd_o.has_cp = 1'b1;
        cmd_o.cp     = {13'd0, in_byte_i};
      end else if ((in_byte_i[7:5] == 3'b110) || (in_byte_i[7:4] == 4'b1110) ||
                   (in_byte_i[7:3] == 5'b11110)) begin
        if (end_of_text_i) begin
          cmd_o.has_cp = 1'b1;
        end else begin
          rcv_cnt_d = 2'd1;
          if (in_byte_i[7:5] == 3'b110) begin
            exp_len_d = utf8d_pkg::LEN_TWO;
            partial_d = {16'd0, in_byte_i[4:0]};
          end else if (in_byte_i[7:4] == 4'b1110) begin
            exp_len_d = utf8d_pkg::LEN_THREE;
            partial_d = {17'd0, in_byte_i[3:0]};
          end else begin
            exp_len_d = utf8d_pkg::LEN_FOUR;
            partial_d = {18'd0, in_byte_i[2:0]};
          end
        end
      end else begin
        cmd_o.has_cp = 1'b1;
      end
    end
  end

  assign push_o = accept_i && ((cmd_o.rep != 2'd0) || cmd_o.has_cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= utf8d_pkg::LEN_NONE;
      rcv_cnt_q <= 2'd0;
      partial_q <= '0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      rcv_cnt_q <= rcv_cnt_d;
      partial_q <= partial_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8d_fifo.sv
`default_nettype none
module utf8d_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire utf8d_pkg::cmd_t     push_data_i,
  input  wire logic                pop_i,
  output utf8d_pkg::cmd_t          head_o,
  output utf8d_pkg::fifo_status_t  status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utf8d_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign head_o          = mem[rd_ptr_q];
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.full   = (cnt_q == FULL_CNT);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8d_back.sv
`default_nettype none
module utf8d_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire utf8d_pkg::cmd_t     head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [20:0]              code_point_o,
  output logic                     run_last_o
);

  logic        out_valid_q;
  logic [20:0] cp_q;
  logic        last_q;
  logic [1:0]  idx_q;

  logic        load;
  logic [2:0]  total;
  logic [2:0]  idx_next;
  logic        is_last;
  logic [20:0] cur_cp;

  always_comb begin
    total    = {1'b0, head_i.rep} + {2'b00, head_i.has_cp};
    idx_next = {1'b0, idx_q} + 3'd1;
    is_last  = (idx_next == total);
    cur_cp   = (idx_q < head_i.rep) ? utf8d_pkg::REPLACEMENT_CP : head_i.cp;
    load     = !empty_i && (!out_valid_q || !out_stall_i);
  end

  assign pop_o        = load && is_last;
  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign run_last_o   = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cur_cp;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_next[1:0];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8_stream_decoder_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   in_byte_i[7:0], end_of_text_i
// out      output     out_valid_o / out_stall_i code_point_o[20:0], run_last_o
//
// One byte is taken per cycle while in_stall_o is low; each byte queues zero to four results.
// The output side drains one result per cycle from the queue while out_stall_i is low.
// in_stall_o rises only when the command queue holds QUEUE_DEPTH entries,
// which happens when the output stalls or multi-result bytes outpace the drain.
// Reset clears the sequence state, the queue and the output valid flag.
`default_nettype none
module utf8_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      code_point_o,
  output logic             run_last_o
);

  logic                    accept;
  logic                    push;
  logic                    pop;
  utf8d_pkg::cmd_t         cmd;
  utf8d_pkg::cmd_t         head;
  utf8d_pkg::fifo_status_t status;

  assign in_stall_o = status.full;
  assign accept     = in_valid_i && !status.full;

  utf8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  utf8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (status)
  );

  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (status.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .run_last_o   (run_last_o)
  );

endmodule
`default_nettype wire
